// ===== rtl/core/hslm_pkg.sv =====
// Package: phase codes, command codes and register indexes for the serial link master.
package hslm_pkg;

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_TX_WAIT_LOW  = 3'd1;
    localparam logic [2:0] PH_TX_WAIT_HIGH = 3'd2;
    localparam logic [2:0] PH_RX_PRE       = 3'd3;
    localparam logic [2:0] PH_RX_HIGH      = 3'd4;
    localparam logic [2:0] PH_RX_LOW       = 3'd5;

    localparam logic [1:0] MODE_SEND = 2'd1;
    localparam logic [1:0] MODE_RECV = 2'd2;

    localparam logic [1:0] REG_PRE_DELAY = 2'd0;
    localparam logic [1:0] REG_HIGH      = 2'd1;
    localparam logic [1:0] REG_LOW       = 2'd2;

    localparam logic [15:0] PRE_DELAY_RESET = 16'd50;
    localparam logic [15:0] HIGH_RESET      = 16'd10;
    localparam logic [15:0] LOW_RESET       = 16'd10;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef logic [15:0] tick_t;

endpackage

// ===== rtl/core/hslm_if.sv =====
// Interfaces: command channel and result channel of the serial link master.
interface hslm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       want_pre_delay;
    logic       ack_level;
    logic       recv_level;

    modport source (
        output valid, mode, tx_byte, want_pre_delay, ack_level, recv_level,
        input  ready
    );
    modport sink (
        input  valid, mode, tx_byte, want_pre_delay, ack_level, recv_level,
        output ready
    );
endinterface

interface hslm_res_if;
    logic       valid;
    logic       ready;
    logic       clk_level;
    logic       data_level;
    logic       busy_res;
    logic       tx_done;
    logic       rx_done;
    logic [7:0] rx_byte;

    modport source (
        output valid, clk_level, data_level, busy_res, tx_done, rx_done, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, clk_level, data_level, busy_res, tx_done, rx_done, rx_byte,
        output ready
    );
endinterface

// ===== rtl/core/handshake_serial_link_master.sv =====
// Top level: master side of a three-wire handshaked serial link, one tick per beat.
// The result beat of an accepted command beat is registered and valid in the next cycle.
// Throughput: one beat per cycle while the result side keeps up; the state update is a single registered pass.
// A new command beat is taken while the result register is empty or being drained.
// Reset (rst_n, async, active low): idle, lines low, counters and rx byte zero,
// tick registers back to 50 / 10 / 10, result register empty.
module handshake_serial_link_master
    import hslm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    hslm_cmd_if.sink      cmd,
    hslm_res_if.source    res
);

    tick_t       pre_delay_reg;
    tick_t       high_reg;
    tick_t       low_reg;

    logic [2:0]  phase_reg,     phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg,     shift_next;
    tick_t       tick_reg,      tick_next;
    logic        clk_out_reg,   clk_out_next;
    logic        data_out_reg,  data_out_next;
    logic [7:0]  last_rx_reg,   last_rx_next;
    logic        tx_done_reg,   tx_done_next;
    logic        rx_done_reg,   rx_done_next;
    logic        res_valid_reg;

    logic        accept;
    logic        expired;
    logic [3:0]  bit_inc;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign expired   = (tick_reg <= 16'd1);
    assign bit_inc   = bit_index_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_delay_reg <= PRE_DELAY_RESET;
            high_reg      <= HIGH_RESET;
            low_reg       <= LOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRE_DELAY: pre_delay_reg <= cfg_data;
                REG_HIGH:      high_reg      <= cfg_data;
                REG_LOW:       low_reg       <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        clk_out_next   = clk_out_reg;
        data_out_next  = data_out_reg;
        last_rx_next   = last_rx_reg;
        tx_done_next   = 1'b0;
        rx_done_next   = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd.mode == MODE_SEND)
                begin
                    shift_next     = cmd.tx_byte;
                    bit_index_next = 4'd0;
                    phase_next     = PH_TX_WAIT_LOW;
                end
                else if (cmd.mode == MODE_RECV)
                begin
                    shift_next     = 8'd0;
                    bit_index_next = 4'd0;
                    if (cmd.want_pre_delay && pre_delay_reg != 16'd0)
                    begin
                        phase_next = PH_RX_PRE;
                        tick_next  = pre_delay_reg;
                    end
                    else
                    begin
                        clk_out_next = 1'b1;
                        phase_next   = PH_RX_HIGH;
                        tick_next    = high_reg;
                    end
                end
            end
            PH_TX_WAIT_LOW:
            begin
                if (!cmd.ack_level)
                begin
                    clk_out_next = 1'b1;
                    phase_next   = PH_TX_WAIT_HIGH;
                end
            end
            PH_TX_WAIT_HIGH:
            begin
                if (cmd.ack_level)
                begin
                    data_out_next = shift_reg[0];
                    shift_next    = {1'b0, shift_reg[7:1]};
                    clk_out_next  = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        bit_index_next = 4'd0;
                        phase_next     = PH_IDLE;
                        tx_done_next   = 1'b1;
                    end
                    else
                    begin
                        bit_index_next = bit_inc;
                        phase_next     = PH_TX_WAIT_LOW;
                    end
                end
            end
            PH_RX_PRE:
            begin
                if (expired)
                begin
                    clk_out_next = 1'b1;
                    phase_next   = PH_RX_HIGH;
                    tick_next    = high_reg;
                end
                else
                begin
                    tick_next = tick_reg - 16'd1;
                end
            end
            PH_RX_HIGH:
            begin
                if (expired)
                begin
                    shift_next     = {cmd.recv_level, shift_reg[7:1]};
                    bit_index_next = bit_inc;
                    clk_out_next   = 1'b0;
                    phase_next     = PH_RX_LOW;
                    tick_next      = low_reg;
                end
                else
                begin
                    tick_next = tick_reg - 16'd1;
                end
            end
            PH_RX_LOW:
            begin
                if (expired)
                begin
                    if (bit_index_reg >= BITS_PER_BYTE)
                    begin
                        last_rx_next   = shift_reg;
                        bit_index_next = 4'd0;
                        phase_next     = PH_IDLE;
                        rx_done_next   = 1'b1;
                    end
                    else
                    begin
                        clk_out_next = 1'b1;
                        phase_next   = PH_RX_HIGH;
                        tick_next    = high_reg;
                    end
                end
                else
                begin
                    tick_next = tick_reg - 16'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= 16'd0;
            clk_out_reg   <= 1'b0;
            data_out_reg  <= 1'b0;
            last_rx_reg   <= 8'd0;
            tx_done_reg   <= 1'b0;
            rx_done_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                tick_reg      <= tick_next;
                clk_out_reg   <= clk_out_next;
                data_out_reg  <= data_out_next;
                last_rx_reg   <= last_rx_next;
                tx_done_reg   <= tx_done_next;
                rx_done_reg   <= rx_done_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result beat reads state directly: state only moves when the old beat is gone
    assign res.valid      = res_valid_reg;
    assign res.clk_level  = clk_out_reg;
    assign res.data_level = data_out_reg;
    assign res.busy_res   = (phase_reg != PH_IDLE);
    assign res.tx_done    = tx_done_reg;
    assign res.rx_done    = rx_done_reg;
    assign res.rx_byte    = last_rx_reg;

endmodule

// ===== dv/tb_handshake_serial_link_master.sv =====
`timescale 1ns / 1ps
// Testbench: serial link master, command beats checked against a beat-exact pin model.
module tb_handshake_serial_link_master;
    import hslm_pkg::*;

    localparam int CYCLE_LIMIT     = 100_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 4;
    localparam int TICKS_PER_PHASE = 25;
    localparam int MAX_REPORTS     = 10;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_RARE} stall_kind_e;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tx_byte;
        logic       want_pre;
        logic       ack;
        logic       rcv;
    } tick_cmd_t;

    typedef struct packed {
        logic       clk_level;
        logic       data_level;
        logic       busy;
        logic       tx_done;
        logic       rx_done;
        logic [7:0] rx_byte;
    } pin_state_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    hslm_cmd_if cmd_ch ();
    hslm_res_if res_ch ();

    handshake_serial_link_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // model of the master
    logic [2:0] m_phase;
    logic [3:0] m_bits;
    logic [7:0] m_shift;
    tick_t      m_ticks;
    logic       m_clk;
    logic       m_data;
    logic [7:0] m_last;
    tick_t      m_pre;
    tick_t      m_high;
    tick_t      m_low;

    pin_state_t expected_pins[$];
    int         fails = 0;
    int         cycles = 0;
    int         burst_left = 0;
    int         ticks_sent = 0;
    int         hold_off_req = 0;
    bit         quiet = 1'b0;

    function automatic bit timer_expired();
        if (m_ticks > 16'd1)
        begin
            m_ticks = m_ticks - 16'd1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void enter_high();
        m_clk   = 1'b1;
        m_phase = PH_RX_HIGH;
        m_ticks = m_high;
    endfunction

    function automatic pin_state_t master_step(tick_cmd_t c);
        pin_state_t r;
        logic       txd;
        logic       rxd;
        txd = 1'b0;
        rxd = 1'b0;
        case (m_phase)
            PH_IDLE:
            begin
                if (c.mode == MODE_SEND)
                begin
                    m_shift = c.tx_byte;
                    m_bits  = '0;
                    m_phase = PH_TX_WAIT_LOW;
                end
                else if (c.mode == MODE_RECV)
                begin
                    m_shift = '0;
                    m_bits  = '0;
                    if (c.want_pre && m_pre != '0)
                    begin
                        m_phase = PH_RX_PRE;
                        m_ticks = m_pre;
                    end
                    else
                        enter_high();
                end
            end
            PH_TX_WAIT_LOW:
            begin
                if (!c.ack)
                begin
                    m_clk   = 1'b1;
                    m_phase = PH_TX_WAIT_HIGH;
                end
            end
            PH_TX_WAIT_HIGH:
            begin
                if (c.ack)
                begin
                    m_data  = m_shift[0];
                    m_shift = m_shift >> 1;
                    m_clk   = 1'b0;
                    m_bits  = m_bits + 4'd1;
                    if (m_bits >= BITS_PER_BYTE)
                    begin
                        m_bits  = '0;
                        m_phase = PH_IDLE;
                        txd     = 1'b1;
                    end
                    else
                        m_phase = PH_TX_WAIT_LOW;
                end
            end
            PH_RX_PRE:
            begin
                if (timer_expired())
                    enter_high();
            end
            PH_RX_HIGH:
            begin
                if (timer_expired())
                begin
                    m_shift = {c.rcv, m_shift[7:1]};
                    m_bits  = m_bits + 4'd1;
                    m_clk   = 1'b0;
                    m_phase = PH_RX_LOW;
                    m_ticks = m_low;
                end
            end
            PH_RX_LOW:
            begin
                if (timer_expired())
                begin
                    if (m_bits >= BITS_PER_BYTE)
                    begin
                        m_last  = m_shift;
                        m_bits  = '0;
                        m_phase = PH_IDLE;
                        rxd     = 1'b1;
                    end
                    else
                        enter_high();
                end
            end
            default: m_phase = PH_IDLE;
        endcase
        r.clk_level  = m_clk;
        r.data_level = m_data;
        r.busy       = (m_phase != PH_IDLE);
        r.tx_done    = txd;
        r.rx_done    = rxd;
        r.rx_byte    = m_last;
        return r;
    endfunction

    function automatic void note_fail(string msg);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("%0t ERROR: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            note_fail($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endfunction

    // one command beat; bursts with random gaps unless quiet
    task automatic send_tick(input tick_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (!quiet && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        cmd_ch.valid          <= 1'b1;
        cmd_ch.mode           <= c.mode;
        cmd_ch.tx_byte        <= c.tx_byte;
        cmd_ch.want_pre_delay <= c.want_pre;
        cmd_ch.ack_level      <= c.ack;
        cmd_ch.recv_level     <= c.rcv;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expected_pins.push_back(master_step(c));
        ticks_sent++;
    endtask

    // start beat, then partner ticks until the master is idle again
    task automatic run_transfer(input logic [1:0] mode, input logic [7:0] tx_byte,
                                input logic want_pre, input logic [7:0] rx_src,
                                input int ack_good, input int noise_pct);
        tick_cmd_t c;
        c.mode     = mode;
        c.tx_byte  = tx_byte;
        c.want_pre = want_pre;
        c.ack      = 1'($urandom_range(0, 1));
        c.rcv      = 1'($urandom_range(0, 1));
        send_tick(c);
        while (m_phase != PH_IDLE)
        begin
            c.mode     = 2'($urandom_range(0, 3));
            c.tx_byte  = 8'($urandom_range(0, 255));
            c.want_pre = 1'($urandom_range(0, 1));
            c.ack      = 1'($urandom_range(0, 1));
            c.rcv      = 1'($urandom_range(0, 1));
            if ($urandom_range(1, 100) > noise_pct)
                c.mode = MODE_TICK;
            if ((m_phase == PH_TX_WAIT_LOW || m_phase == PH_TX_WAIT_HIGH)
                && $urandom_range(1, 100) <= ack_good)
                c.ack = (m_phase == PH_TX_WAIT_HIGH);
            if (m_phase == PH_RX_HIGH)
                c.rcv = rx_src[m_bits[2:0]];
            send_tick(c);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input tick_t val);
        cmd_ch.valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PRE_DELAY: m_pre  = val;
            REG_HIGH:      m_high = val;
            REG_LOW:       m_low  = val;
            default:       ;
        endcase
    endtask

    task automatic test_plain_ticks();
        run_transfer(MODE_TICK, 8'hFF, 1'b1, 8'h00, 100, 0);
        run_transfer(MODE_SPARE, 8'h00, 1'b1, 8'h00, 100, 0);
        run_transfer(MODE_TICK, 8'h00, 1'b0, 8'h00, 100, 0);
    endtask

    task automatic test_send_bytes();
        run_transfer(MODE_SEND, 8'h00, 1'b0, 8'h00, 100, 0);
        run_transfer(MODE_SEND, 8'hFF, 1'b1, 8'h00, 100, 0);
        run_transfer(MODE_SEND, 8'h5A, 1'b0, 8'h00, 100, 0);
        run_transfer(MODE_SEND, 8'hC3, 1'b0, 8'h00, 40, 0);
    endtask

    task automatic test_recv_bytes();
        run_transfer(MODE_RECV, 8'h00, 1'b1, 8'hA5, 100, 0);
        write_reg(REG_PRE_DELAY, 16'd4);
        write_reg(REG_HIGH, 16'd2);
        write_reg(REG_LOW, 16'd3);
        run_transfer(MODE_RECV, 8'hFF, 1'b0, 8'hFF, 100, 0);
        run_transfer(MODE_RECV, 8'h00, 1'b1, 8'h00, 100, 0);
    endtask

    task automatic test_busy_commands();
        run_transfer(MODE_SEND, 8'h96, 1'b0, 8'h00, 90, 100);
        run_transfer(MODE_RECV, 8'h69, 1'b0, 8'h3C, 100, 100);
    endtask

    // zero high/low timings act as one tick, zero pre-delay skips it; longer timings run without idling
    task automatic test_timing_extremes();
        write_reg(REG_HIGH, 16'd0);
        write_reg(REG_LOW, 16'd0);
        write_reg(REG_PRE_DELAY, 16'd0);
        run_transfer(MODE_RECV, 8'h00, 1'b1, 8'h81, 100, 0);
        write_reg(REG_PRE_DELAY, 16'd1);
        write_reg(REG_HIGH, 16'd1);
        write_reg(REG_LOW, 16'd1);
        run_transfer(MODE_RECV, 8'h00, 1'b1, 8'h7E, 100, 0);
        quiet = 1'b1;
        write_reg(REG_PRE_DELAY, 16'd16);
        write_reg(REG_HIGH, 16'd6);
        write_reg(REG_LOW, 16'd0);
        run_transfer(MODE_RECV, 8'h00, 1'b1, 8'hC5, 100, 0);
        write_reg(REG_HIGH, 16'd1);
        write_reg(REG_LOW, 16'd6);
        run_transfer(MODE_RECV, 8'h00, 1'b0, 8'h2B, 100, 0);
        quiet = 1'b0;
    endtask

    // receiver holds off while commands keep coming
    task automatic test_backpressure();
        write_reg(REG_PRE_DELAY, 16'd2);
        write_reg(REG_HIGH, 16'd3);
        write_reg(REG_LOW, 16'd3);
        hold_off_req++;
        run_transfer(MODE_RECV, 8'h00, 1'b1, 8'($urandom_range(0, 255)), 100, 0);
        run_transfer(MODE_SEND, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 100, 5);
    endtask

    task automatic test_random();
        int         target;
        int         pick;
        logic [1:0] mode;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(REG_PRE_DELAY, 16'($urandom_range(0, 8)));
            write_reg(REG_HIGH, 16'($urandom_range(0, 4)));
            write_reg(REG_LOW, 16'($urandom_range(0, 4)));
            target = ticks_sent + TICKS_PER_PHASE;
            while (ticks_sent < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    mode = MODE_SEND;
                else if (pick < 8)
                    mode = MODE_RECV;
                else if (pick == 8)
                    mode = MODE_SPARE;
                else
                    mode = MODE_TICK;
                run_transfer(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), $urandom_range(50, 100),
                             $urandom_range(0, 10));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("handshake_serial_link_master regression: fail");
        $finish;
    end

    // result side stalls, with a long hold-off on request
    initial
    begin
        int          hold_left;
        int          hold_seen;
        int          pat_left;
        int          count;
        stall_kind_e pat;
        hold_left = 0;
        hold_seen = 0;
        pat_left  = 0;
        count     = 0;
        pat       = STALL_NONE;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req != hold_seen)
            begin
                hold_seen = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (pat_left == 0)
            begin
                pat      = stall_kind_e'($urandom_range(0, 3));
                pat_left = $urandom_range(20, 200);
            end
            pat_left--;
            count++;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (quiet)
                res_ch.ready <= 1'b1;
            else
            begin
                case (pat)
                    STALL_NONE:  res_ch.ready <= 1'b1;
                    STALL_COIN:  res_ch.ready <= 1'($urandom_range(0, 1));
                    STALL_THIRD: res_ch.ready <= (count % 3 == 0);
                    default:     res_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        pin_state_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_pins.size() == 0)
                note_fail("result beat with nothing expected");
            else
            begin
                want = expected_pins.pop_front();
                check_field("clk_level", 8'(want.clk_level), 8'(res_ch.clk_level));
                check_field("data_level", 8'(want.data_level), 8'(res_ch.data_level));
                check_field("busy_res", 8'(want.busy), 8'(res_ch.busy_res));
                check_field("tx_done", 8'(want.tx_done), 8'(res_ch.tx_done));
                check_field("rx_done", 8'(want.rx_done), 8'(res_ch.rx_done));
                check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
            end
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_PRE_DELAY;
        cfg_data              <= '0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.mode           <= MODE_TICK;
        cmd_ch.tx_byte        <= '0;
        cmd_ch.want_pre_delay <= 1'b0;
        cmd_ch.ack_level      <= 1'b0;
        cmd_ch.recv_level     <= 1'b0;
        m_phase = PH_IDLE;
        m_bits  = '0;
        m_shift = '0;
        m_ticks = '0;
        m_clk   = 1'b0;
        m_data  = 1'b0;
        m_last  = '0;
        m_pre   = PRE_DELAY_RESET;
        m_high  = HIGH_RESET;
        m_low   = LOW_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_ticks();
        test_send_bytes();
        test_recv_bytes();
        test_busy_commands();
        test_timing_extremes();
        test_backpressure();
        test_random();

        cmd_ch.valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fails == 0)
            $display("handshake_serial_link_master regression: pass");
        else
            $display("handshake_serial_link_master regression: fail");
        $finish;
    end

endmodule

// ===== handshake_serial_link_master.f =====
rtl/core/hslm_pkg.sv
rtl/core/hslm_if.sv
rtl/core/handshake_serial_link_master.sv
dv/tb_handshake_serial_link_master.sv
